// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ipv4tlp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4tlp_pkg
// Types and constants of the IPv4 timeout line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4tlp_pkg;

	localparam int TMO_BITS = 32;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [8:0] OCTET_SAT  = 9'd256;
	localparam logic [1:0] LAST_OCTET = 2'd3;

	typedef enum logic [2:0] {
		PH_LEAD = 3'd0,
		PH_ADDR = 3'd1,
		PH_GAP  = 3'd2,
		PH_TMO  = 3'd3,
		PH_TAIL = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ADDR  = 2'd0,
		KIND_PAUSE = 2'd1,
		KIND_BAD   = 2'd2
	} line_kind_t;

endpackage

`default_nettype wire

// ===== design/ipv4_timeout_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_timeout_line_parser_core
// Parses "[spaces] (P | a.b.c.d<sp>) [spaces] [timeout]" lines, one
// character per transfer, and gives one result per line.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                      tuser           tlast
//  s_axis   in   [7:0] ch                   -               ends_text
//  m_axis   out  [31:0] ipv4_address,       [1:0] line_kind -
//                [63:32] timeout_value
//
//  One character per cycle while s_axis_tready is high; the line state updates at the transfer.
//  The result is registered and shows in the cycle after the transfer of the newline or the
//  character with tlast.
//  s_axis_tready drops only while a result waits and m_axis_tready is low.
//  Reset clears the line state and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_timeout_line_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // ends_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [31:0] ipv4_address, [63:32] timeout_value
	output logic [1:0]       m_axis_tuser    // [1:0] line_kind
);
	import ipv4tlp_pkg::*;

	phase_t              phase_q;
	logic [1:0]          oct_idx_q;
	logic [8:0]          oct_val_q;
	logic                dig_seen_q;
	logic [31:0]         addr_q;
	logic [TMO_BITS-1:0] tmo_q;
	logic                pause_q;
	logic                bad_q;

	phase_t              p_phase;
	logic [1:0]          p_oct_idx;
	logic [8:0]          p_oct_val;
	logic                p_dig_seen;
	logic [31:0]         p_addr;
	logic [TMO_BITS-1:0] p_tmo;
	logic                p_pause;
	logic                p_bad;

	logic                s_fire;
	logic                is_nl, is_digit, is_space, is_sep, addr_step, emit, final_bad;
	logic [3:0]          dig;
	logic [11:0]         oct_mul;
	logic [8:0]          oct_sat;
	logic [TMO_BITS+3:0] tmo_mul;
	logic [TMO_BITS-1:0] tmo_sat;
	logic [TMO_BITS+31:0] tmo_ext;

	line_kind_t          kind_q;
	logic [31:0]         out_addr_q;
	logic [31:0]         out_tmo_q;
	logic                out_valid_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	assign is_nl    = s_axis_tdata == CH_NL;
	assign is_space = s_axis_tdata == CH_SPACE;
	assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
	assign dig      = 4'(s_axis_tdata - CH_ZERO);
	assign is_sep   = ((oct_idx_q != LAST_OCTET) && (s_axis_tdata == CH_DOT)) ||
	                  ((oct_idx_q == LAST_OCTET) && is_space);

	assign oct_mul = {3'd0, oct_val_q} * 12'd10 + {8'd0, dig};
	assign oct_sat = (oct_mul > {3'd0, OCTET_SAT}) ? OCTET_SAT : oct_mul[8:0];

	assign tmo_mul = ({4'd0, tmo_q} << 3) + ({4'd0, tmo_q} << 1) + {{TMO_BITS{1'b0}}, dig};
	assign tmo_sat = (tmo_mul[TMO_BITS+3:TMO_BITS] != 4'd0) ? {TMO_BITS{1'b1}}
	                                                        : tmo_mul[TMO_BITS-1:0];

	always_comb begin
		p_phase    = phase_q;
		p_oct_idx  = oct_idx_q;
		p_oct_val  = oct_val_q;
		p_dig_seen = dig_seen_q;
		p_addr     = addr_q;
		p_tmo      = tmo_q;
		p_pause    = pause_q;
		p_bad      = bad_q;
		addr_step  = 1'b0;
		if (!is_nl) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (is_space) begin
					end else if (s_axis_tdata == CH_P) begin
						p_pause = 1'b1;
						p_phase = PH_GAP;
					end else begin
						p_phase   = PH_ADDR;
						addr_step = 1'b1;
					end
				end
				PH_ADDR: addr_step = 1'b1;
				PH_GAP: begin
					if (is_space) begin
					end else if (is_digit) begin
						p_tmo   = tmo_sat;
						p_phase = PH_TMO;
					end else begin
						p_phase = PH_TAIL;
					end
				end
				PH_TMO: begin
					if (is_digit) begin
						p_tmo = tmo_sat;
					end else begin
						p_phase = PH_TAIL;
					end
				end
				default: begin
				end
			endcase
			if (addr_step) begin
				if (is_digit) begin
					p_oct_val  = oct_sat;
					p_dig_seen = 1'b1;
				end else if (is_sep) begin
					if (!dig_seen_q || oct_val_q[8]) begin
						p_bad   = 1'b1;
						p_phase = PH_TAIL;
					end else begin
						p_addr     = {addr_q[23:0], oct_val_q[7:0]};
						p_oct_val  = 9'd0;
						p_dig_seen = 1'b0;
						if (oct_idx_q == LAST_OCTET) begin
							p_phase = PH_GAP;
						end else begin
							p_oct_idx = oct_idx_q + 2'd1;
						end
					end
				end else begin
					p_bad   = 1'b1;
					p_phase = PH_TAIL;
				end
			end
		end
	end

	assign emit      = is_nl || s_axis_tlast;
	assign final_bad = p_bad || (p_phase == PH_LEAD) || (p_phase == PH_ADDR);
	assign tmo_ext   = {32'd0, p_tmo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			oct_idx_q  <= 2'd0;
			oct_val_q  <= 9'd0;
			dig_seen_q <= 1'b0;
			addr_q     <= 32'd0;
			tmo_q      <= '0;
			pause_q    <= 1'b0;
			bad_q      <= 1'b0;
		end else if (s_fire) begin
			if (emit) begin
				phase_q    <= PH_LEAD;
				oct_idx_q  <= 2'd0;
				oct_val_q  <= 9'd0;
				dig_seen_q <= 1'b0;
				addr_q     <= 32'd0;
				tmo_q      <= '0;
				pause_q    <= 1'b0;
				bad_q      <= 1'b0;
			end else begin
				phase_q    <= p_phase;
				oct_idx_q  <= p_oct_idx;
				oct_val_q  <= p_oct_val;
				dig_seen_q <= p_dig_seen;
				addr_q     <= p_addr;
				tmo_q      <= p_tmo;
				pause_q    <= p_pause;
				bad_q      <= p_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && emit) begin
			if (final_bad) begin
				kind_q     <= KIND_BAD;
				out_addr_q <= 32'd0;
				out_tmo_q  <= 32'd0;
			end else begin
				kind_q     <= p_pause ? KIND_PAUSE : KIND_ADDR;
				out_addr_q <= p_pause ? 32'd0 : p_addr;
				out_tmo_q  <= tmo_ext[31:0];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_tmo_q, out_addr_q};
	assign m_axis_tuser  = kind_q;

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_bad_zero, m_axis_tvalid && (m_axis_tuser == KIND_BAD),
		m_axis_tdata == 64'd0, "malformed line with nonzero payload")
	`ASSERT_IMPLIES(a_pause_addr, m_axis_tvalid && (m_axis_tuser == KIND_PAUSE),
		m_axis_tdata[31:0] == 32'd0, "pause entry with nonzero address")
	`ASSERT_NEXT(a_nl_clears, s_fire && is_nl,
		(phase_q == PH_LEAD) && (oct_idx_q == 2'd0) && !bad_q && !pause_q,
		"line state not cleared after newline")
	`ASSERT_IMPLIES(a_rise_src, $rose(out_valid_q), $past(s_fire && emit),
		"result appeared without a terminating transfer")
	`ASSERT_ALWAYS(a_oct_range, oct_val_q <= OCTET_SAT, "octet value above saturation")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Streams text into ipv4_timeout_line_parser_core one character per transfer
// and checks every line result against a local parser model. A short
// directed set comes first. Random lines follow, mostly well formed, some
// corrupted and some noise. Three phases are run, two with backpressure and one without.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv4tlp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam logic [63:0] TMO_MAX = ((64'd1 << (TMO_BITS - 1)) - 64'd1) * 64'd2 + 64'd1;

	typedef logic [7:0] char_t;

	typedef struct packed {
		line_kind_t  kind;
		logic [31:0] addr;
		logic [31:0] tmo;
	} line_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
	logic        s_axis_tlast = 1'b0;    // ends_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;           // [31:0] ipv4_address, [63:32] timeout_value
	logic [1:0]  m_axis_tuser;           // [1:0] line_kind

	ipv4_timeout_line_parser_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int errors = 0;
	int cycles = 0;

	line_entry_t pending_lines[$];
	char_t       line_buf[$];
	bit          line_mark;

	// parser model state
	phase_t      cur_phase;
	logic [1:0]  oct_idx;
	logic [8:0]  oct_val;
	bit          oct_digit;
	logic [31:0] addr_acc;
	logic [63:0] tmo_acc;
	bit          pause_seen;
	bit          line_bad;

	function automatic void clear_line();
		cur_phase  = PH_LEAD;
		oct_idx    = '0;
		oct_val    = '0;
		oct_digit  = 1'b0;
		addr_acc   = '0;
		tmo_acc    = '0;
		pause_seen = 1'b0;
		line_bad   = 1'b0;
	endfunction

	function automatic void close_line();
		line_entry_t r;
		if (cur_phase == PH_LEAD || cur_phase == PH_ADDR)
			line_bad = 1'b1;
		if (line_bad) begin
			r.kind = KIND_BAD;
			r.addr = '0;
			r.tmo  = '0;
		end else begin
			r.kind = pause_seen ? KIND_PAUSE : KIND_ADDR;
			r.addr = pause_seen ? 32'd0 : addr_acc;
			r.tmo  = tmo_acc[31:0];
		end
		pending_lines.push_back(r);
		clear_line();
	endfunction

	function automatic void add_tmo_digit(input char_t c);
		logic [63:0] d;
		d = 64'(c - CH_ZERO);
		if (tmo_acc > (TMO_MAX - d) / 64'd10)
			tmo_acc = TMO_MAX;
		else
			tmo_acc = tmo_acc * 64'd10 + d;
	endfunction

	function automatic void addr_char(input char_t c, input bit is_digit);
		int v;
		if (is_digit) begin
			v = int'(oct_val) * 10 + int'(c) - int'(CH_ZERO);
			oct_val = (v > int'(OCTET_SAT)) ? OCTET_SAT : v[8:0];
			oct_digit = 1'b1;
		end else if ((oct_idx < LAST_OCTET && c == CH_DOT) ||
				(oct_idx == LAST_OCTET && c == CH_SPACE)) begin
			if (!oct_digit || oct_val >= OCTET_SAT) begin
				line_bad = 1'b1;
				cur_phase = PH_TAIL;
			end else begin
				addr_acc = {addr_acc[23:0], oct_val[7:0]};
				oct_val = '0;
				oct_digit = 1'b0;
				if (oct_idx == LAST_OCTET)
					cur_phase = PH_GAP;
				else
					oct_idx = oct_idx + 2'd1;
			end
		end else begin
			line_bad = 1'b1;
			cur_phase = PH_TAIL;
		end
	endfunction

	function automatic void parse_char(input char_t c, input bit last);
		bit is_digit;
		is_digit = (c >= CH_ZERO && c <= CH_NINE);
		if (c == CH_NL) begin
			close_line();
			return;
		end
		case (cur_phase)
			PH_LEAD: begin
				if (c == CH_SPACE) begin
				end else if (c == CH_P) begin
					pause_seen = 1'b1;
					cur_phase = PH_GAP;
				end else begin
					cur_phase = PH_ADDR;
					addr_char(c, is_digit);
				end
			end
			PH_ADDR: addr_char(c, is_digit);
			PH_GAP: begin
				if (c == CH_SPACE) begin
				end else if (is_digit) begin
					add_tmo_digit(c);
					cur_phase = PH_TMO;
				end else begin
					cur_phase = PH_TAIL;
				end
			end
			PH_TMO: begin
				if (is_digit)
					add_tmo_digit(c);
				else
					cur_phase = PH_TAIL;
			end
			default: begin
			end
		endcase
		if (last)
			close_line();
	endfunction

	// one character transfer, with random sender gaps
	task automatic send_char(input char_t c, input bit last);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		parse_char(c, last);
	endtask

	task automatic send_text(input string s, input bit mark_final);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], mark_final && (i == s.len() - 1));
	endtask

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic int pick_octet();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return $urandom_range(999, 256);
		if (r < 15)
			return ($urandom_range(1) != 0) ? 255 : 0;
		return $urandom_range(255);
	endfunction

	// builds one random line into line_buf
	function automatic void make_line();
		int kind;
		int n;
		kind = $urandom_range(99);
		line_buf = {};
		line_mark = 1'b0;
		repeat ($urandom_range(2)) line_buf.push_back(CH_SPACE);
		if (kind < 12) begin
			repeat ($urandom_range(12, 1)) line_buf.push_back(char_t'($urandom_range(255)));
		end else begin
			if (kind < 32) begin
				line_buf.push_back(CH_P);
			end else begin
				for (int i = 0; i < 4; i++) begin
					push_text($sformatf("%0d", pick_octet()));
					line_buf.push_back((i < 3) ? CH_DOT : CH_SPACE);
				end
			end
			repeat ($urandom_range(2)) line_buf.push_back(CH_SPACE);
			n = $urandom_range(19);
			if (n == 0)
				push_text(($urandom_range(1) != 0) ? "4294967295" : "4294967296");
			else if (n < 3)
				repeat ($urandom_range(14, 10))
					line_buf.push_back(CH_ZERO + char_t'($urandom_range(9)));
			else
				repeat ($urandom_range(6))
					line_buf.push_back(CH_ZERO + char_t'($urandom_range(9)));
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(3, 1)) line_buf.push_back(char_t'($urandom_range(255)));
			if (kind < 22)
				line_buf[$urandom_range(line_buf.size() - 1)] = char_t'($urandom_range(255));
		end
		if ($urandom_range(19) == 0) begin
			line_mark = 1'b1;
			if ($urandom_range(1) != 0 || line_buf.size() == 0)
				line_buf.push_back(CH_NL);
		end else begin
			line_buf.push_back(CH_NL);
		end
	endfunction

	task automatic test_directed();
		send_text("\n", 1'b0);
		send_text(" P7x\n", 1'b0);
		send_text("9.0.255.1  5", 1'b1);
		send_text("256.\n", 1'b0);
		send_text(".\n", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(CH_NL, 1'b1);
		send_char(CH_P, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_NL, 1'b0);
	endtask

	task automatic test_random_lines(input int n_chars);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			make_line();
			for (int i = 0; i < line_buf.size(); i++)
				send_char(line_buf[i], line_mark && (i == line_buf.size() - 1));
			sent += line_buf.size();
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

	always @(posedge clk) begin : check_results
		line_entry_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_lines.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d addr %h timeout %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
			end else begin
				want = pending_lines.pop_front();
				if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.addr ||
						m_axis_tdata[63:32] !== want.tmo) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp kind %0d addr %h timeout %0d, got kind %0d addr %h timeout %0d",
							want.kind, want.addr, want.tmo,
							m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clear_line();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle_pct = 37;
		rcv_idle_pct = 68;
		test_directed();
		test_random_lines(550);
		snd_idle_pct = 68;
		rcv_idle_pct = 37;
		test_random_lines(550);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_lines(550);
		s_axis_tvalid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
